>>> src/fhc_pkg.sv
// shared types, constants and the byte-wide crc-32 step for the frame header crc checker
// used by every module under src
`default_nettype none

package fhc_pkg;

  // widths of the header fields
  localparam int unsigned MagicWidth = 32;
  localparam int unsigned FieldWidth = 16;
  localparam int unsigned CrcWidth   = 32;
  localparam int unsigned ByteWidth  = 8;

  // default for the size limit used by the capacity check
  localparam int unsigned SizeBitsDefault = 16;

  // header byte positions
  localparam logic [3:0] IdxMagicEnd   = 4'd3;
  localparam logic [3:0] IdxVersionEnd = 4'd5;
  localparam logic [3:0] IdxSizeEnd    = 4'd7;
  localparam logic [3:0] IdxCrcEnd     = 4'd11;
  localparam logic [3:0] IdxPayload    = 4'd12;

  localparam logic [CrcWidth-1:0] CrcAllOnes = 32'hFFFF_FFFF;
  localparam logic [CrcWidth-1:0] CrcPoly    = 32'hEDB8_8320;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_MAGIC    = 2'd0,
    REG_VERSION  = 2'd1,
    REG_SIZE     = 2'd2,
    REG_CAPACITY = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_MAGIC   = 3'd1,
    ST_BAD_VERSION = 3'd2,
    ST_BAD_SIZE    = 3'd3,
    ST_TOO_SHORT   = 3'd4,
    ST_BAD_CRC     = 3'd5
  } status_t;

  // what the front hands to the back
  typedef enum logic [1:0] {
    KIND_FAIL = 2'd0,  // header check failed, report status
    KIND_HEAD = 2'd1,  // header complete, data holds the header crc
    KIND_DATA = 2'd2   // payload byte in data[7:0]
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic                 last;
    status_t              status;
    logic [CrcWidth-1:0]  data;
  } entry_t;

  typedef struct packed {
    status_t              status;
    logic [CrcWidth-1:0]  crc;
  } result_t;

  // one byte through the reflected crc-32, lsb first
  function automatic logic [CrcWidth-1:0] crc_byte(input logic [CrcWidth-1:0] crc_in,
                                                    input logic [ByteWidth-1:0] b);
    logic [CrcWidth-1:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < ByteWidth; k++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : '0);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> src/fhc_front.sv
// front part: configuration registers, header assembly and the header checks
// depends on fhc_pkg; emits one entry per word that needs work in the back
`default_nettype none

module fhc_front
  import fhc_pkg::*;
#(
  parameter int unsigned SIZE_BITS = SizeBitsDefault
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [MagicWidth-1:0] cfg_data,
  input  wire logic                  take,
  input  wire logic [ByteWidth-1:0]  frame_byte,
  input  wire logic                  frame_start,
  output logic                       push_valid,
  output entry_t                     push_entry
);

  localparam logic [FieldWidth-1:0] CapLimit =
    FieldWidth'((33'd1 << SIZE_BITS) - 33'd1);

  logic [MagicWidth-1:0] magic_word;
  logic [FieldWidth-1:0] expected_version;
  logic [FieldWidth-1:0] expected_size;
  logic [FieldWidth-1:0] payload_capacity;

  logic [3:0]            header_index, header_index_next;
  logic [FieldWidth-1:0] payload_count, payload_count_next;
  logic [FieldWidth-1:0] header_size, header_size_next;
  logic [MagicWidth-1:0] header_shift, header_shift_next;
  logic                  frame_done, frame_done_next;

  logic [3:0]            idx_eff;
  logic [FieldWidth-1:0] count_eff;
  logic [FieldWidth-1:0] size_eff;
  logic [MagicWidth-1:0] shift_eff;
  logic                  done_eff;
  logic [MagicWidth-1:0] shift_in;
  logic [FieldWidth-1:0] count_inc;
  logic [FieldWidth-1:0] cap;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word       <= '0;
      expected_version <= '0;
      expected_size    <= '0;
      payload_capacity <= '1;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_MAGIC:    magic_word       <= cfg_data;
        REG_VERSION:  expected_version <= cfg_data[FieldWidth-1:0];
        REG_SIZE:     expected_size    <= cfg_data[FieldWidth-1:0];
        REG_CAPACITY: payload_capacity <= cfg_data[FieldWidth-1:0];
        default: ;
      endcase
    end
  end

  // frame start restarts the header
  assign idx_eff   = frame_start ? '0 : header_index;
  assign count_eff = frame_start ? '0 : payload_count;
  assign size_eff  = frame_start ? '0 : header_size;
  assign shift_eff = frame_start ? '0 : header_shift;
  assign done_eff  = frame_start ? 1'b0 : frame_done;

  assign shift_in  = {frame_byte, shift_eff[MagicWidth-1:ByteWidth]};
  assign count_inc = count_eff + FieldWidth'(1);
  assign cap       = (payload_capacity > CapLimit) ? CapLimit : payload_capacity;

  // classify the word and update the header state
  always_comb begin
    header_index_next  = idx_eff;
    payload_count_next = count_eff;
    header_size_next   = size_eff;
    header_shift_next  = shift_eff;
    frame_done_next    = done_eff;
    push_valid         = 1'b0;
    push_entry.kind    = KIND_FAIL;
    push_entry.last    = 1'b1;
    push_entry.status  = ST_OK;
    push_entry.data    = '0;

    if (done_eff) begin
      // no frame in progress, word dropped
    end else if (idx_eff >= IdxPayload) begin
      payload_count_next = count_inc;
      push_valid         = 1'b1;
      push_entry.kind    = KIND_DATA;
      push_entry.last    = (count_inc >= size_eff);
      push_entry.data    = {24'd0, frame_byte};
      frame_done_next    = (count_inc >= size_eff);
    end else begin
      header_shift_next = shift_in;
      header_index_next = idx_eff + 4'd1;
      priority case (idx_eff)
        IdxMagicEnd: begin
          if (shift_in != magic_word) begin
            push_valid        = 1'b1;
            push_entry.status = ST_BAD_MAGIC;
            frame_done_next   = 1'b1;
          end
        end
        IdxVersionEnd: begin
          if (shift_in[MagicWidth-1:FieldWidth] != expected_version) begin
            push_valid        = 1'b1;
            push_entry.status = ST_BAD_VERSION;
            frame_done_next   = 1'b1;
          end
        end
        IdxSizeEnd: begin
          header_size_next = shift_in[MagicWidth-1:FieldWidth];
          if (shift_in[MagicWidth-1:FieldWidth] != expected_size) begin
            push_valid        = 1'b1;
            push_entry.status = ST_BAD_SIZE;
            frame_done_next   = 1'b1;
          end else if (cap < shift_in[MagicWidth-1:FieldWidth]) begin
            push_valid        = 1'b1;
            push_entry.status = ST_TOO_SHORT;
            frame_done_next   = 1'b1;
          end
        end
        IdxCrcEnd: begin
          header_index_next = IdxPayload;
          push_valid        = 1'b1;
          push_entry.kind   = KIND_HEAD;
          push_entry.last   = (size_eff == '0);
          push_entry.data   = shift_in;
          frame_done_next   = (size_eff == '0);
        end
        default: ;
      endcase
    end
    if (!take) begin
      push_valid = 1'b0;
    end
  end

  // header state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_index  <= '0;
      payload_count <= '0;
      header_size   <= '0;
      header_shift  <= '0;
      frame_done    <= 1'b1;
    end else if (take) begin
      header_index  <= header_index_next;
      payload_count <= payload_count_next;
      header_size   <= header_size_next;
      header_shift  <= header_shift_next;
      frame_done    <= frame_done_next;
    end
  end

endmodule

`default_nettype wire

>>> src/fhc_queue.sv
// short flip-flop queue of entries between the front and the back
// depends on fhc_pkg for the entry type
`default_nettype none

module fhc_queue
  import fhc_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  entry_t    in_entry,
  output logic      full,
  output logic      out_valid,
  output entry_t    out_entry,
  input  wire logic out_ready
);

  localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntWidth = $clog2(DEPTH + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
  localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

  entry_t                slots [DEPTH];
  logic [PtrWidth-1:0]   wr_ptr;
  logic [PtrWidth-1:0]   rd_ptr;
  logic [CntWidth-1:0]   count;
  logic                  do_push;
  logic                  do_pop;

  assign full      = (count == FullCnt);
  assign out_valid = (count != '0);
  assign out_entry = slots[rd_ptr];
  assign do_push   = in_valid && !full;
  assign do_pop    = out_valid && out_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= in_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrWidth'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrWidth'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CntWidth'(1);
        2'b01:   count <= count - CntWidth'(1);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/fhc_back.sv
// back part: running crc over payload words, final compare and result register
// depends on fhc_pkg for entries, results and the crc step
`default_nettype none

module fhc_back
  import fhc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  entry_t    in_entry,
  output logic      in_ready,
  output logic      res_valid,
  output result_t   res,
  input  wire logic res_ready
);

  logic [CrcWidth-1:0] running_crc, running_crc_next;
  logic [CrcWidth-1:0] header_crc, header_crc_next;
  logic [CrcWidth-1:0] crc_step;
  logic [CrcWidth-1:0] final_crc;
  logic                emits;
  logic                slot_free;
  logic                do_take;
  result_t             res_next;

  assign crc_step  = crc_byte(running_crc, in_entry.data[ByteWidth-1:0]);
  assign emits     = (in_entry.kind == KIND_FAIL) || in_entry.last;
  assign slot_free = !res_valid || res_ready;
  assign in_ready  = !emits || slot_free;
  assign do_take   = in_valid && in_ready;

  // crc update and result forming
  always_comb begin
    running_crc_next = running_crc;
    header_crc_next  = header_crc;
    final_crc        = '0;
    res_next.status  = ST_OK;
    res_next.crc     = '0;
    unique case (in_entry.kind)
      KIND_FAIL: begin
        res_next.status = in_entry.status;
      end
      KIND_HEAD: begin
        running_crc_next = CrcAllOnes;
        header_crc_next  = in_entry.data;
        res_next.status  = (in_entry.data == '0) ? ST_OK : ST_BAD_CRC;
      end
      KIND_DATA: begin
        running_crc_next = crc_step;
        final_crc        = crc_step ^ CrcAllOnes;
        res_next.crc     = final_crc;
        res_next.status  = (final_crc == header_crc) ? ST_OK : ST_BAD_CRC;
      end
      default: ;
    endcase
  end

  // crc state
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= CrcAllOnes;
      header_crc  <= '0;
    end else if (do_take) begin
      running_crc <= running_crc_next;
      header_crc  <= header_crc_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (do_take && emits) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_take && emits) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

>>> src/frame_header_crc_checker.sv
// frame header crc checker: one word per cycle while full is low, the crc unit takes a byte a
// cycle unless an entry that ends a result waits for the result register to be popped; that
// entry is queued when its word is accepted, then passes the crc unit into the result register
// full rises only when the four-entry queue is full because results are not popped
// rst (synchronous) clears the queue and result, waits for frame start, capacity reads 65535
// depends on fhc_pkg, fhc_front, fhc_queue, fhc_back
`default_nettype none

module frame_header_crc_checker
  import fhc_pkg::*;
#(
  parameter int unsigned SIZE_BITS   = SizeBitsDefault,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [MagicWidth-1:0] cfg_data,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [ByteWidth-1:0]  frame_byte,
  input  wire logic                  frame_start,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [2:0]                 status,
  output logic [CrcWidth-1:0]        computed_crc
);

  logic    take;
  logic    front_valid;
  entry_t  front_entry;
  logic    q_valid;
  entry_t  q_entry;
  logic    back_ready;
  logic    res_valid;
  result_t res;

  assign take = push && !full;

  // header parsing and checks
  fhc_front #(
    .SIZE_BITS(SIZE_BITS)
  ) u_front (
    .clk,
    .rst,
    .cfg_write,
    .cfg_index,
    .cfg_data,
    .take,
    .frame_byte,
    .frame_start,
    .push_valid(front_valid),
    .push_entry(front_entry)
  );

  // decoupling queue
  fhc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk,
    .rst,
    .in_valid (front_valid),
    .in_entry (front_entry),
    .full,
    .out_valid(q_valid),
    .out_entry(q_entry),
    .out_ready(back_ready)
  );

  // crc and result
  fhc_back u_back (
    .clk,
    .rst,
    .in_valid (q_valid),
    .in_entry (q_entry),
    .in_ready (back_ready),
    .res_valid,
    .res,
    .res_ready(pop)
  );

  assign empty        = !res_valid;
  assign status       = res.status;
  assign computed_crc = res.crc;

endmodule

`default_nettype wire
